>>> src/ftc_pkg.sv
// shared types and constants of the fuzzy temperature controller
package ftc_pkg;

  localparam int RIDX_W  = 6;
  localparam int RCNT_W  = 7;
  localparam int PADDR_W = 2;

  localparam logic [PADDR_W-1:0] REG_RULE_COUNT = 2'd0;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [1:0] KIND_TOO_COLD = 2'd0;
  localparam logic [1:0] KIND_COLD     = 2'd1;
  localparam logic [1:0] KIND_WARM     = 2'd2;
  localparam logic [1:0] KIND_TOO_WARM = 2'd3;

  localparam logic [14:0] Q14_ONE    = 15'd16384;
  localparam logic [14:0] GAUSS_GAIN = 15'd16345;

  localparam logic signed [18:0] DEG3    = 19'sd768;
  localparam logic signed [18:0] DEG5    = 19'sd1280;
  localparam logic signed [18:0] DEG10   = 19'sd2560;
  localparam logic signed [18:0] DEG15   = 19'sd3840;
  localparam logic signed [18:0] DEG25   = 19'sd6400;
  localparam logic signed [18:0] DEG30   = 19'sd7680;
  localparam logic signed [18:0] DEG40   = 19'sd10240;
  localparam logic signed [18:0] NEG_INF = -19'sd131072;
  localparam logic signed [18:0] POS_INF = 19'sd131071;

  localparam logic [33:0] DEN_WIDE    = 34'd209715200;
  localparam logic [33:0] DEN_NARROW  = 34'd52428800;
  localparam logic [33:0] HALF_WIDE   = 34'd104857600;
  localparam logic [33:0] HALF_NARROW = 34'd26214400;
  localparam logic [17:0] RECIP5      = 18'd209716;

  typedef struct packed {
    logic              load_we;
    logic              eval_start;
    logic              issue_valid;
    logic [RIDX_W-1:0] issue_rule;
    logic [1:0]        issue_kind;
    logic              issue_last;
    logic              div_start;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [RCNT_W-1:0] rule_n;
    logic              acc_done;
    logic              div_done;
  } sts_t;

  typedef struct packed {
    logic       v;
    logic [1:0] kind;
    logic       last;
    logic       mode;
    logic       wsig;
  } tag_t;

endpackage

>>> src/ftc_div.sv
// restoring divider, one quotient bit per cycle
module ftc_div #(
  parameter int DVW = 19,
  parameter int DSW = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic [DVW-1:0] quot_o,
  output logic           done_o
);
  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DSW-1:0]  rem_q, rem_d;
  logic [DVW-1:0]  quo_q;
  logic [DSW:0]    trial;
  logic            qbit;

  always_comb begin
    trial = {rem_q, quo_q[DVW-1]};
    qbit  = (trial >= {1'b0, divisor_i});
    rem_d = qbit ? DSW'(trial - {1'b0, divisor_i}) : trial[DSW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(DVW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVW-2:0], qbit};
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;
endmodule

>>> src/ftc_ctrl.sv
// controller: accepts beats, issues memberships, sequences divide and output
module ftc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ftc_pkg::cmd_t cmd_o,
  input  ftc_pkg::sts_t sts_i
);
  import ftc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [RIDX_W-1:0] j_q, j_d;
  logic [1:0]        kind_q, kind_d;
  logic              out_valid_q, out_valid_d;
  logic              last;

  assign last = ({1'b0, j_q} == sts_i.rule_n - 1'b1) && (kind_q == KIND_TOO_WARM);

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.eval_start = 1'b1;
            j_d     = '0;
            kind_d  = KIND_TOO_COLD;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.issue_valid = 1'b1;
        cmd_o.issue_rule  = j_q;
        cmd_o.issue_kind  = kind_q;
        cmd_o.issue_last  = last;
        if (kind_q == KIND_TOO_WARM) begin
          kind_d = KIND_TOO_COLD;
          j_d    = j_q + 1'b1;
        end else begin
          kind_d = kind_q + 1'b1;
        end
        if (last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.acc_done) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done && (!out_valid_q || out_ready_i)) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      kind_q      <= KIND_TOO_COLD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

>>> src/ftc_datapath.sv
// datapath: rule table, membership pipeline, accumulator, divide and output register
module ftc_datapath #(
  parameter int MAX_RULES       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftc_pkg::cmd_t       cmd_i,
  output ftc_pkg::sts_t       sts_o,
  input  logic [3:0]          rule_index_i,
  input  logic                rule_mode_i,
  input  logic signed [15:0]  rule_center_i,
  input  logic signed [15:0]  temperature_i,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  output logic [4:0]          rule_count_o,
  output logic signed [15:0]  drive_value_o
);
  import ftc_pkg::*;

  localparam int AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW    = $clog2(MAX_RULES + 1);
  localparam int SW    = 15 + CW;
  localparam int DVW   = 14 + CW;
  localparam int XW    = 28 + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int YW    = $clog2(25 * (EXP_TABLE_DEPTH + 1) + 1);
  localparam int R     = YW + 5;
  localparam int RECIP25 = (2 ** R) / 25;
  localparam int MW    = $clog2(RECIP25 + 1);
  localparam int PW    = YW + MW;
  localparam int QW    = $clog2(EXP_TABLE_DEPTH + 2);
  localparam int RAW   = $clog2(EXP_TABLE_DEPTH);

  function automatic logic [15:0] exp_entry(input int unsigned k);
    logic [63:0]        t, term, s;
    logic signed [63:0] acc;
    t    = (64'(k) << 30) / 64'(2 * EXP_TABLE_DEPTH);
    term = 64'd1 << 30;
    acc  = signed'(term);
    term = ((term * t) >> 30) / 1;  acc = acc - signed'(term);
    term = ((term * t) >> 30) / 2;  acc = acc + signed'(term);
    term = ((term * t) >> 30) / 3;  acc = acc - signed'(term);
    term = ((term * t) >> 30) / 4;  acc = acc + signed'(term);
    term = ((term * t) >> 30) / 5;  acc = acc - signed'(term);
    term = ((term * t) >> 30) / 6;  acc = acc + signed'(term);
    term = ((term * t) >> 30) / 7;  acc = acc - signed'(term);
    term = ((term * t) >> 30) / 8;  acc = acc + signed'(term);
    term = ((term * t) >> 30) / 9;  acc = acc - signed'(term);
    term = ((term * t) >> 30) / 10; acc = acc + signed'(term);
    term = ((term * t) >> 30) / 11; acc = acc - signed'(term);
    term = ((term * t) >> 30) / 12; acc = acc + signed'(term);
    term = ((term * t) >> 30) / 13; acc = acc - signed'(term);
    term = ((term * t) >> 30) / 14; acc = acc + signed'(term);
    s = (acc > 0) ? unsigned'(acc) : 64'd0;
    for (int i = 0; i < 5; i++) s = (s * s + (64'd1 << 29)) >> 30;
    return 16'((s + (64'd1 << 15)) >> 16);
  endfunction

  // exp rom
  logic [14:0] rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [15:0] ENTRY = exp_entry(g);
    assign rom[g] = ENTRY[14:0];
  end

  // config register
  logic [4:0]    rc_q;
  logic [CW-1:0] n_eff;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rc_q <= 5'd1;
    else if (cfg_we_i) rc_q <= cfg_wdata_i;
  end
  always_comb begin
    if (rc_q == 5'd0) n_eff = CW'(1);
    else if (32'(rc_q) > MAX_RULES) n_eff = CW'(MAX_RULES);
    else n_eff = CW'(rc_q);
  end
  assign rule_count_o = rc_q;

  // rule table
  logic signed [15:0] center_mem [MAX_RULES];
  logic               mode_mem   [MAX_RULES];
  logic [MAX_RULES-1:0] vld_q;
  logic [AW-1:0]      waddr, raddr;
  logic               wr_en;
  logic signed [15:0] rd_center_q;
  logic               rd_mode_q, rd_vld_q;

  assign waddr = AW'(rule_index_i);
  assign raddr = AW'(cmd_i.issue_rule);
  assign wr_en = cmd_i.load_we && (32'(rule_index_i) < MAX_RULES);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      center_mem[waddr] <= rule_center_i;
      mode_mem[waddr]   <= rule_mode_i;
    end
    if (cmd_i.issue_valid) begin
      rd_center_q <= center_mem[raddr];
      rd_mode_q   <= mode_mem[raddr];
      rd_vld_q    <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (wr_en) vld_q[waddr] <= 1'b1;
  end

  logic signed [15:0] f_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) f_q <= temperature_i;
  end

  // pipeline tags
  tag_t tag_q [8];
  logic eff_mode;
  assign eff_mode = rd_vld_q & rd_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) tag_q[i] <= '0;
    end else begin
      tag_q[0] <= '{v: cmd_i.issue_valid, kind: cmd_i.issue_kind,
                    last: cmd_i.issue_last, mode: 1'b0, wsig: 1'b0};
      tag_q[1] <= '{v: tag_q[0].v, kind: tag_q[0].kind, last: tag_q[0].last,
                    mode: eff_mode,
                    wsig: (tag_q[0].kind == KIND_TOO_COLD) ||
                          (tag_q[0].kind == KIND_TOO_WARM)};
      for (int i = 2; i < 8; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  // stage 1: offsets and linear segment select
  logic signed [18:0] x19, b19, m19, p1, p2, p3, p4;
  logic               lz, lo, lr;
  always_comb begin
    x19 = 19'(f_q);
    b19 = rd_vld_q ? 19'(rd_center_q) : 19'sd0;
    case (tag_q[0].kind)
      KIND_TOO_COLD: begin
        p1 = NEG_INF; p2 = NEG_INF; p3 = DEG10; p4 = DEG15; m19 = 19'sd0;
      end
      KIND_COLD: begin
        p1 = DEG10; p2 = DEG15; p3 = b19 - DEG5; p4 = b19 + DEG3; m19 = b19 - DEG5;
      end
      KIND_WARM: begin
        p1 = b19 - DEG3; p2 = b19 + DEG5; p3 = DEG25; p4 = DEG30; m19 = b19 + DEG5;
      end
      default: begin
        p1 = DEG25; p2 = DEG30; p3 = POS_INF; p4 = POS_INF; m19 = DEG40;
      end
    endcase
    lz = (x19 <= p1) || (x19 >= p4);
    lo = !lz && (x19 >= p2) && (x19 <= p3);
    lr = !lz && !lo && (x19 < p2);
  end

  logic signed [17:0] d_q;
  logic               lz2_q, lo2_q, linv2_q, lwide2_q;
  logic [10:0]        lnum2_q;
  always_ff @(posedge clk_i) begin
    d_q      <= 18'(x19 - m19);
    lz2_q    <= lz;
    lo2_q    <= lo;
    linv2_q  <= !lz && !lo && !lr;
    lwide2_q <= lr ? (tag_q[0].kind == KIND_WARM) : (tag_q[0].kind == KIND_COLD);
    lnum2_q  <= lr ? 11'(x19 - p1) : 11'(x19 - p3);
  end

  // stage 2: square and ramp reciprocal product
  logic signed [35:0] sq_full;
  logic [16:0]        lin_a;
  assign sq_full = d_q * d_q;
  assign lin_a   = {lnum2_q, 6'd0} + 17'd2;

  logic [33:0] sq_q;
  logic        lz3_q, lo3_q, linv3_q, lwide3_q;
  logic [10:0] lnum3_q;
  logic [34:0] lprod_q;
  always_ff @(posedge clk_i) begin
    sq_q     <= sq_full[33:0];
    lz3_q    <= lz2_q;
    lo3_q    <= lo2_q;
    linv3_q  <= linv2_q;
    lwide3_q <= lwide2_q;
    lnum3_q  <= lnum2_q;
    lprod_q  <= 35'(lin_a) * 35'(RECIP5);
  end

  // stage 3: scale to rom index, finish linear value
  logic        big3;
  logic [14:0] frac3, lval3;
  assign big3  = sq_q >= (tag_q[2].wsig ? DEN_WIDE : DEN_NARROW);
  assign frac3 = lwide3_q ? 15'({lnum3_q, 3'd0}) : 15'(lprod_q >> 20);
  always_comb begin
    if (lz3_q) lval3 = '0;
    else if (lo3_q) lval3 = Q14_ONE;
    else if (linv3_q) lval3 = Q14_ONE - frac3;
    else lval3 = frac3;
  end

  logic [XW-1:0] x_q;
  logic          big4_q, big5_q;
  logic [14:0]   linval_q [4];
  always_ff @(posedge clk_i) begin
    x_q    <= XW'(sq_q[27:0]) * XW'(EXP_TABLE_DEPTH) +
              XW'(tag_q[2].wsig ? HALF_WIDE : HALF_NARROW);
    big4_q <= big3;
    linval_q[0] <= lval3;
    for (int i = 1; i < 4; i++) linval_q[i] <= linval_q[i-1];
  end

  // stage 4: divide by 25 through reciprocal
  logic [YW-1:0] y4;
  logic [PW-1:0] qprod4;
  assign y4     = tag_q[3].wsig ? YW'(x_q >> 23) : YW'(x_q >> 21);
  assign qprod4 = PW'(y4) * PW'(RECIP25);

  logic [YW-1:0] y_q;
  logic [QW-1:0] q0_q;
  always_ff @(posedge clk_i) begin
    y_q    <= y4;
    q0_q   <= QW'(qprod4 >> R);
    big5_q <= big4_q;
  end

  // stage 5: quotient correction and rom read
  logic [YW-1:0]  rr5;
  logic [QW:0]    qq5;
  logic           gz5;
  logic [RAW-1:0] raddr5;
  assign rr5    = y_q - YW'(q0_q * 25);
  assign qq5    = (QW+1)'(q0_q) + (QW+1)'(rr5 >= 25);
  assign gz5    = big5_q || (32'(qq5) >= EXP_TABLE_DEPTH);
  assign raddr5 = gz5 ? '0 : RAW'(qq5);

  logic [14:0] rom_q;
  logic        gz6_q, gz7_q;
  always_ff @(posedge clk_i) begin
    rom_q <= rom[raddr5];
    gz6_q <= gz5;
  end

  // stage 6: gain
  logic [29:0] gprod_q;
  always_ff @(posedge clk_i) begin
    gprod_q <= 30'(GAUSS_GAIN) * 30'(rom_q);
    gz7_q   <= gz6_q;
  end

  // stage 7: round and select
  logic [14:0] gm7, mval_q;
  assign gm7 = gz7_q ? 15'd0 : 15'((gprod_q + 30'd8192) >> 14);
  always_ff @(posedge clk_i) begin
    mval_q <= tag_q[6].mode ? linval_q[3] : gm7;
  end

  // accumulate heat minus vent
  logic [14:0]          hold_q, heat_q, vent;
  logic signed [SW-1:0] sum_q;
  logic                 acc_done_q;
  assign vent = (hold_q > mval_q) ? hold_q : mval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      sum_q <= '0;
    end else if (tag_q[7].v) begin
      case (tag_q[7].kind)
        KIND_TOO_COLD: hold_q <= mval_q;
        KIND_COLD:     heat_q <= (hold_q > mval_q) ? hold_q : mval_q;
        KIND_WARM:     hold_q <= mval_q;
        default:       sum_q  <= sum_q + SW'($signed({1'b0, heat_q}))
                                       - SW'($signed({1'b0, vent}));
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_done_q <= 1'b0;
    else acc_done_q <= tag_q[7].v && tag_q[7].last;
  end

  // rounded average
  logic           neg;
  logic [SW-1:0]  mag;
  logic [DVW-1:0] dividend, quot;
  logic           div_done;
  assign neg      = sum_q[SW-1];
  assign mag      = neg ? SW'(-sum_q) : SW'(sum_q);
  assign dividend = DVW'(mag) + DVW'(n_eff >> 1);

  ftc_div #(.DVW(DVW), .DSW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (n_eff),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  logic [14:0]        qsat;
  logic signed [15:0] drive_q;
  assign qsat = (quot > DVW'(Q14_ONE)) ? Q14_ONE : 15'(quot);
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) drive_q <= neg ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
  end
  assign drive_value_o = drive_q;

  assign sts_o.rule_n   = RCNT_W'(n_eff);
  assign sts_o.acc_done = acc_done_q;
  assign sts_o.div_done = div_done;
endmodule

>>> src/fuzzy_temperature_controller.sv
// top level of the fuzzy temperature controller
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | action, rule_index, rule_mode, rule_center, temperature
//  out     | out_valid/out_ready| drive_value
//  config  | apb write/read     | rule_count at byte address 0
//
// a load beat writes one rule slot; an evaluate beat issues four memberships per
// rule over the n effective rules: one membership enters the pipeline each cycle,
// then the bit-serial divider forms the rounded average
// reset clears the rule table through per-slot valid bits, rule_count to 1
// a result waiting on out_ready does not block loads; the next evaluate holds
// its result in the divider until the output register is free
module fuzzy_temperature_controller #(
  parameter int MAX_RULES       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [3:0]                  rule_index_i,
  input  logic                        rule_mode_i,
  input  logic signed [15:0]          rule_center_i,
  input  logic signed [15:0]          temperature_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [15:0]          drive_value_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ftc_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_we;
  logic [4:0] rule_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_RULE_COUNT);
  assign prdata = (paddr == REG_RULE_COUNT) ? {27'd0, rule_count} : 32'd0;

  ftc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ftc_datapath #(
    .MAX_RULES       (MAX_RULES),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rule_index_i  (rule_index_i),
    .rule_mode_i   (rule_mode_i),
    .rule_center_i (rule_center_i),
    .temperature_i (temperature_i),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[4:0]),
    .rule_count_o  (rule_count),
    .drive_value_o (drive_value_o)
  );
endmodule

>>> tb/sv/ftc_checker.sv
// drive value predictor and in-order result checker for the fuzzy temperature controller
module ftc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        action_i,
  input  logic [3:0]                  rule_index_i,
  input  logic                        rule_mode_i,
  input  logic signed [15:0]          rule_center_i,
  input  logic signed [15:0]          temperature_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [15:0]          drive_value_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [ftc_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic                        pready_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          drives_o,
  output int                          loads_o
);
  import ftc_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int EXP_DEPTH   = 256;
  localparam int ONE_Q14     = 16384;

  int unsigned         exp_q14 [EXP_DEPTH];
  int                  center_tbl [TABLE_DEPTH];
  logic                mode_tbl [TABLE_DEPTH];
  logic [4:0]          rule_count_r;
  logic signed [15:0]  drive_q [$];

  function automatic void build_exp();
    longint unsigned t, term, s;
    longint          acc;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      t = (longint'(k) << 30) / (2 * EXP_DEPTH);
      term = 64'd1 << 30;
      acc = longint'(term);
      for (int n = 1; n <= 14; n++) begin
        term = ((term * t) >> 30) / n;
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      s = (acc > 0) ? longint'(acc) : 0;
      for (int q = 0; q < 5; q++) s = (s * s + (64'd1 << 29)) >> 30;
      exp_q14[k] = int'((s + (64'd1 << 15)) >> 16);
    end
  endfunction

  function automatic int gauss_q14(int x, int ctr, longint unsigned den);
    longint          d;
    longint unsigned d2, k;
    d = longint'(x) - longint'(ctr);
    d2 = d * d;
    k = (d2 * EXP_DEPTH + den / 2) / den;
    if (k >= EXP_DEPTH) return 0;
    return (int'(GAUSS_GAIN) * int'(exp_q14[k]) + 8192) >>> 14;
  endfunction

  function automatic int frac_q14(int num, int den);
    return (num * ONE_Q14 + den / 2) / den;
  endfunction

  function automatic int fall_q14(int x, int p1, int p2);
    if (x <= p1) return ONE_Q14;
    if (x >= p2) return 0;
    return ONE_Q14 - frac_q14(x - p1, p2 - p1);
  endfunction

  function automatic int rise_q14(int x, int p1, int p2);
    if (x <= p1) return 0;
    if (x >= p2) return ONE_Q14;
    return frac_q14(x - p1, p2 - p1);
  endfunction

  function automatic int trap_q14(int x, int p1, int p2, int p3, int p4);
    if (x <= p1 || x >= p4) return 0;
    if (x >= p2 && x <= p3) return ONE_Q14;
    if (x > p1 && x < p2) return frac_q14(x - p1, p2 - p1);
    return ONE_Q14 - frac_q14(x - p3, p4 - p3);
  endfunction

  function automatic int max_q14(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [15:0] predict_drive(int f);
    int n, total, avg, b, heat, vent;
    n = int'(rule_count_r);
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    total = 0;
    for (int j = 0; j < n; j++) begin
      b = center_tbl[j];
      if (!mode_tbl[j]) begin
        heat = max_q14(gauss_q14(f, 0, DEN_WIDE), gauss_q14(f, b - DEG5, DEN_NARROW));
        vent = max_q14(gauss_q14(f, b + DEG5, DEN_NARROW), gauss_q14(f, DEG40, DEN_WIDE));
      end else begin
        heat = max_q14(fall_q14(f, DEG10, DEG15),
                       trap_q14(f, DEG10, DEG15, b - DEG5, b + DEG3));
        vent = max_q14(trap_q14(f, b - DEG3, b + DEG5, DEG25, DEG30),
                       rise_q14(f, DEG25, DEG30));
      end
      total += heat - vent;
    end
    if (total >= 0) avg = (total + n / 2) / n;
    else avg = -((-total + n / 2) / n);
    if (avg > ONE_Q14) avg = ONE_Q14;
    if (avg < -ONE_Q14) avg = -ONE_Q14;
    return avg[15:0];
  endfunction

  initial begin
    build_exp();
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      center_tbl[j] = 0;
      mode_tbl[j] = 1'b0;
    end
    rule_count_r = 5'd1;
    fail_count_o = 0;
    drives_o = 0;
    loads_o = 0;
  end

  assign pending_o = drive_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == REG_RULE_COUNT)
        rule_count_r = pwdata_i[4:0];
      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_LOAD) begin
          center_tbl[rule_index_i] = int'(rule_center_i);
          mode_tbl[rule_index_i] = rule_mode_i;
          loads_o++;
        end else begin
          drive_q.push_back(predict_drive(int'(temperature_i)));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected drive beat, actual %0d", $time, drive_value_i);
          fail_count_o++;
        end else begin
          if (drive_value_i !== drive_q[0]) begin
            $display("%0t: drive_value mismatch, expected %0d actual %0d",
                     $time, drive_q[0], drive_value_i);
            fail_count_o++;
          end
          void'(drive_q.pop_front());
          drives_o++;
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// stimulus, idling and verdict for the fuzzy temperature controller testbench
module tb_top;
  import ftc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN       = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                action_i;
  logic [3:0]          rule_index_i;
  logic                rule_mode_i;
  logic signed [15:0]  rule_center_i;
  logic signed [15:0]  temperature_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic signed [15:0]  drive_value_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int  fail_count, pending, drives, loads;
  int  cycles;
  bit  hold_req;
  bit  quiet_send;
  bit  quiet_recv;

  fuzzy_temperature_controller i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .rule_index_i, .rule_mode_i,
    .rule_center_i, .temperature_i, .out_valid_o, .out_ready_i, .drive_value_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ftc_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .rule_index_i,
    .rule_mode_i, .rule_center_i, .temperature_i, .out_valid_i(out_valid_o),
    .out_ready_i, .drive_value_i(drive_value_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .drives_o(drives), .loads_o(loads)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("fuzzy_temperature_controller regression: fail");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        gap = quiet_recv ? 0 : pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(logic act, logic [3:0] idx, logic mode,
                           logic signed [15:0] ctr, logic signed [15:0] temp);
    int gap;
    gap = quiet_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    rule_index_i  <= idx;
    rule_mode_i   <= mode;
    rule_center_i <= ctr;
    temperature_i <= temp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic load_rule(logic [3:0] idx, logic mode, logic signed [15:0] ctr);
    send_beat(ACT_LOAD, idx, mode, ctr, 16'($urandom));
  endtask

  task automatic eval_temp(logic signed [15:0] temp);
    send_beat(ACT_EVAL, 4'($urandom), 1'($urandom), 16'($urandom), temp);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_rule_count(logic [31:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RULE_COUNT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_temp();
    if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 80 * 256)) - 20 * 256);
    return 16'($urandom);
  endfunction

  initial begin
    logic [31:0] counts [8];
    int          n_items;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_LOAD;
    rule_index_i  = '0;
    rule_mode_i   = 1'b0;
    rule_center_i = '0;
    temperature_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    quiet_send    = 1'b0;
    quiet_recv    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table at reset count
    eval_temp(16'sd0);
    eval_temp(16'sh7fff);
    eval_temp(-16'sh8000);
    load_rule(4'd0, 1'b1, 16'sd5120);
    eval_temp(16'sd2560);
    eval_temp(16'sd3840);
    eval_temp(16'sd6400);
    eval_temp(16'sd7680);
    write_rule_count(32'd16);
    load_rule(4'd15, 1'b0, 16'sh7fff);
    load_rule(4'd1, 1'b1, -16'sh8000);
    load_rule(4'd2, 1'b0, 16'sd5120);
    load_rule(4'd3, 1'b1, 16'sd0);
    eval_temp(16'sd10240);
    eval_temp(16'sd3840);
    eval_temp(16'sd6400);
    eval_temp(16'sh7fff);
    eval_temp(-16'sh8000);
    eval_temp(16'sd5120 - 16'sd1280);
    eval_temp(16'sd5120 + 16'sd768);
    write_rule_count(32'd0);
    eval_temp(16'sd2560);
    write_rule_count(32'd31);
    eval_temp(16'sd6400);

    counts = '{32'd17, 32'd1, 32'd16, 32'd5, 32'd0, 32'd31, 32'd9, 32'd16};
    n_items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_rule_count(ph == 6 ? 32'($urandom_range(2, 15)) : counts[ph]);
      for (int i = 0; i < 200; i++) begin
        if (i % 50 == 0) begin
          quiet_send = ($urandom_range(0, 3) == 0);
          quiet_recv = ($urandom_range(0, 3) == 0);
        end
        if (ph == 3 && i == 60) hold_req = 1'b1;
        if ($urandom_range(0, 9) < 4) begin
          if ($urandom_range(0, 9) < 7)
            load_rule(4'($urandom), 1'($urandom),
                      16'($signed($urandom_range(0, 60 * 256)) - 10 * 256));
          else
            load_rule(4'($urandom), 1'($urandom), 16'($urandom));
        end else begin
          eval_temp(pick_temp());
        end
        n_items++;
      end
    end

    settle();
    $display("covered %0d table loads and %0d drive results over %0d random items,",
             loads, drives, n_items);
    $display("rule counts 0, 1, mid, 16 and above, both membership modes, full temps");
    if (fail_count == 0)
      $display("fuzzy_temperature_controller regression: pass");
    else
      $display("fuzzy_temperature_controller regression: fail");
    $finish;
  end

endmodule
